// ----- rtl/ofp_pkg.sv -----
// Package for the optical-flow frame parser: payload structs, frame constants
// and item kind codes. Used by every module of the block; depends on nothing.
`default_nettype none

package ofp_pkg;

    localparam logic [7:0] START_BYTE  = 8'hFE;
    localparam logic [7:0] SECOND_BYTE = 8'h04;
    localparam logic [7:0] END_BYTE    = 8'hAA;

    // Frame positions of the byte that is expected next.
    localparam logic [3:0] POS_SECOND      = 4'd1;
    localparam logic [3:0] POS_FIRST_STORE = 4'd2;
    localparam logic [3:0] POS_LAST_SUM    = 4'd7;
    localparam logic [3:0] POS_LAST_STORE  = 4'd9;
    localparam logic [3:0] POS_END         = 4'd10;

    // Indexes into the stored frame bytes (frame position minus two).
    localparam logic [2:0] IDX_FX_LO    = 3'd0;
    localparam logic [2:0] IDX_FX_HI    = 3'd1;
    localparam logic [2:0] IDX_FY_LO    = 3'd2;
    localparam logic [2:0] IDX_FY_HI    = 3'd3;
    localparam logic [2:0] IDX_HT_LO    = 3'd4;
    localparam logic [2:0] IDX_HT_HI    = 3'd5;
    localparam logic [2:0] IDX_CHECKSUM = 3'd6;
    localparam logic [2:0] IDX_QUALITY  = 3'd7;

    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic signed [15:0] flow_x;
        logic signed [15:0] flow_y;
        logic signed [15:0] height;
        logic        [7:0]  quality;
        logic signed [31:0] total_x;
        logic signed [31:0] total_y;
    } t_out;

    // A decoded frame as the parser reports it in the cycle of its end byte.
    typedef struct packed {
        logic               valid;
        logic signed [15:0] flow_x;
        logic signed [15:0] flow_y;
        logic signed [15:0] height;
        logic        [7:0]  quality;
    } t_frame;

endpackage

`default_nettype wire

// ----- rtl/ofp_parser.sv -----
// Frame hunter of the optical-flow frame parser: position tracking, byte store
// and checksum. Depends on ofp_pkg.
`default_nettype none

module ofp_parser import ofp_pkg::*; (
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  wire    i_accept,
    input  t_in    i_item,
    output t_frame o_frame
);

    logic       r_in_frame, n_in_frame;
    logic [3:0] r_pos, n_pos;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_bytes [8];
    logic       n_wr_en;
    logic [2:0] n_wr_idx;
    logic       n_valid;
    logic [7:0] w_byte;

    assign w_byte   = i_item.data_byte;
    assign n_wr_idx = 3'(r_pos - POS_FIRST_STORE);

    always_comb begin
        n_in_frame = r_in_frame;
        n_pos      = r_pos;
        n_sum      = r_sum;
        n_wr_en    = 1'b0;
        n_valid    = 1'b0;
        if (i_accept && (i_item.kind == KIND_BYTE)) begin
            if (!r_in_frame) begin
                if (w_byte == START_BYTE) begin
                    n_in_frame = 1'b1;
                    n_pos      = POS_SECOND;
                    n_sum      = 8'd0;
                end
            end else if (r_pos == POS_SECOND) begin
                if (w_byte == SECOND_BYTE) begin
                    n_pos = POS_FIRST_STORE;
                end else begin
                    n_in_frame = 1'b0;
                    n_pos      = 4'd0;
                    n_sum      = 8'd0;
                end
            end else if ((r_pos >= POS_FIRST_STORE) && (r_pos <= POS_LAST_STORE)) begin
                n_wr_en = 1'b1;
                if (r_pos <= POS_LAST_SUM) begin
                    n_sum = r_sum + w_byte;
                end
                n_pos = r_pos + 4'd1;
            end else begin
                // End byte, or a position that should never arise: either way
                // the hunt starts again with the next byte.
                n_valid    = (r_pos == POS_END) && (w_byte == END_BYTE)
                             && (r_sum == r_bytes[IDX_CHECKSUM]);
                n_in_frame = 1'b0;
                n_pos      = 4'd0;
                n_sum      = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_pos      <= 4'd0;
            r_sum      <= 8'd0;
        end else begin
            r_in_frame <= n_in_frame;
            r_pos      <= n_pos;
            r_sum      <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_wr_en) begin
            r_bytes[n_wr_idx] <= w_byte;
        end
    end

    assign o_frame.valid   = n_valid;
    assign o_frame.flow_x  = {r_bytes[IDX_FX_HI], r_bytes[IDX_FX_LO]};
    assign o_frame.flow_y  = {r_bytes[IDX_FY_HI], r_bytes[IDX_FY_LO]};
    assign o_frame.height  = {r_bytes[IDX_HT_HI], r_bytes[IDX_HT_LO]};
    assign o_frame.quality = r_bytes[IDX_QUALITY];

endmodule

`default_nettype wire

// ----- rtl/ofp_accum.sv -----
// Saturating running totals of the negated x and y flow.
// Depends on ofp_pkg.
`default_nettype none

module ofp_accum import ofp_pkg::*; (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_clear,
    input  wire                i_update,
    input  wire signed [15:0]  i_flow_x,
    input  wire signed [15:0]  i_flow_y,
    output logic signed [31:0] o_total_x,
    output logic signed [31:0] o_total_y
);

    logic signed [31:0] r_acc_x, n_acc_x;
    logic signed [31:0] r_acc_y, n_acc_y;
    logic signed [31:0] w_sub_x, w_sub_y;

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] acc,
                                                   input logic signed [15:0] d);
        logic signed [32:0] diff;
        diff = {acc[31], acc} - {{17{d[15]}}, d};
        if (diff[32] != diff[31]) begin
            sat_sub = diff[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end else begin
            sat_sub = diff[31:0];
        end
    endfunction

    assign w_sub_x = sat_sub(r_acc_x, i_flow_x);
    assign w_sub_y = sat_sub(r_acc_y, i_flow_y);

    always_comb begin
        n_acc_x = r_acc_x;
        n_acc_y = r_acc_y;
        if (i_clear) begin
            n_acc_x = 32'sd0;
            n_acc_y = 32'sd0;
        end else if (i_update) begin
            n_acc_x = w_sub_x;
            n_acc_y = w_sub_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_x <= 32'sd0;
            r_acc_y <= 32'sd0;
        end else begin
            r_acc_x <= n_acc_x;
            r_acc_y <= n_acc_y;
        end
    end

    // Results carry the totals after this frame's update.
    assign o_total_x = n_acc_x;
    assign o_total_y = n_acc_y;

endmodule

`default_nettype wire

// ----- rtl/optical_flow_frame_parser.sv -----
// Top level of the optical-flow serial frame parser: frame hunter, running
// totals and a two-entry output buffer. Depends on ofp_pkg, ofp_parser, ofp_accum.
`default_nettype none

//  channel | direction | payload | handshake
//  --------+-----------+---------+----------------------------------
//  in      | input     | t_in    | i_in_valid / o_in_stall
//  out     | output    | t_out   | o_out_valid / i_out_stall
//
// One item is taken in every cycle unless the input stalls. The result of a
// good frame is registered in the main register, or in the skid register.
// Reset is synchronous and active low; it clears the hunt state, the checksum
// and the totals, and empties the output buffer. Stored frame bytes are not reset.
// The output side has a main register and a skid register, so a transfer is
// taken while a result waits; the input stalls only when both are occupied.

module optical_flow_frame_parser import ofp_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    input  t_in  i_in_data,
    output logic o_in_stall,
    output logic o_out_valid,
    output t_out o_out_data,
    input  wire  i_out_stall
);

    logic   w_accept;
    t_frame w_frame;
    logic   w_clear;
    t_out   w_result;
    logic   w_take;

    logic r_out_valid, n_out_valid;
    logic r_skid_valid, n_skid_valid;
    t_out r_out, n_out;
    t_out r_skid, n_skid;

    // The skid register is only ever full while the input is stalled, so an
    // accepted item always finds room for its result.
    assign o_in_stall = r_skid_valid;
    assign w_accept   = i_in_valid && !r_skid_valid;
    assign w_clear    = w_accept && (i_in_data.kind == KIND_CLEAR);

    ofp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_in_data),
        .o_frame  (w_frame)
    );

    ofp_accum u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (w_clear),
        .i_update  (w_frame.valid),
        .i_flow_x  (w_frame.flow_x),
        .i_flow_y  (w_frame.flow_y),
        .o_total_x (w_result.total_x),
        .o_total_y (w_result.total_y)
    );

    assign w_result.flow_x  = w_frame.flow_x;
    assign w_result.flow_y  = w_frame.flow_y;
    assign w_result.height  = w_frame.height;
    assign w_result.quality = w_frame.quality;

    assign w_take = r_out_valid && !i_out_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (w_take) begin
            // Move a waiting result forward, or empty the main register.
            n_out       = r_skid;
            n_out_valid = r_skid_valid;
            n_skid_valid = 1'b0;
        end
        if (w_frame.valid) begin
            if (!r_out_valid || w_take) begin
                n_out       = w_result;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = w_result;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
